### sv/dsb_pkg.sv
`timescale 1ns / 1ps
// dsb_pkg: types, constants and helper functions for dipole_sensitivity_block.
// No dependencies.
package dsb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 12;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 33;

    typedef logic signed [EW-1:0] t_exp;

    localparam logic [31:0] INV4PI_MANT = 32'd2734261103;
    localparam t_exp        INV4PI_EXP  = t_exp'(-35);
    localparam logic [31:0] CUR_RESET   = 32'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] receiver_x;
        logic signed [31:0] receiver_z;
        logic signed [31:0] cell_x_left;
        logic signed [31:0] cell_x_right;
        logic signed [31:0] cell_z_left;
        logic signed [31:0] cell_z_right;
        logic        [31:0] cell_area;
    } t_in;

    typedef struct packed {
        logic signed [31:0] term_xx;
        logic signed [31:0] term_xz;
        logic signed [31:0] term_zz;
        logic               saturated;
        logic               coincident;
    } t_out;

    // mini-float: mantissa in [2^31, 2^32) or zero
    typedef struct packed {
        logic [31:0] m;
        t_exp        e;
    } t_mf;

    typedef struct packed {
        logic        coinc;
        logic        cneg;
        logic        nxx;
        logic        nxz;
        logic        nzz;
        t_exp        e0;
        logic [5:0]  khalf;
        t_mf         rn;
        t_mf         num;
        t_mf [2:0]   nm;
        t_mf         c;
    } t_ctx;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    function automatic logic [31:0] norm64(input logic [63:0] v, input logic [6:0] lz);
        logic [63:0] s;
        s = v << lz;
        return s[63:32];
    endfunction

    // product of two normalized mantissas, exponent already summed
    function automatic t_mf norm_prod(input logic [63:0] p, input t_exp e);
        t_mf r;
        r.m = p[63] ? p[63:32] : p[62:31];
        r.e = e + (p[63] ? t_exp'(32) : t_exp'(31));
        return r;
    endfunction

    function automatic t_mf norm_quot(input logic [32:0] q, input t_exp e);
        t_mf r;
        r.m = q[32] ? q[32:1] : q[31:0];
        r.e = e + t_exp'(q[32]);
        return r;
    endfunction

    function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [31:0] d);
        logic ge;
        ge = rem >= {1'b0, d};
        return {ge, ge ? rem - {1'b0, d} : rem};
    endfunction

endpackage

### sv/dipole_sensitivity_block.sv
`timescale 1ns / 1ps
// dipole_sensitivity_block: pipelined 2-D magnetic dipole kernel, one 2x2 block per item.
// Depends on dsb_pkg.
//
// Accepts one receiver/cell item every clock and returns one result item per input
// through 111 register stages: 6 front stages (offsets, squares, normalization), a
// 32-stage square root, 2 stages for r^3, a 33-stage divider for the coefficient,
// 3 stages for the numerator products, a 33-stage three-lane divider for the terms
// and 2 stages of fixed-point conversion. The whole pipeline freezes while the output
// item waits; nothing is dropped. source_current should be written only with the
// pipeline empty.
module dipole_sensitivity_block (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dsb_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dsb_pkg::t_out o_out_item
);
    import dsb_pkg::*;

    logic        w_adv;
    logic [31:0] r_cur;

    assign w_adv      = ~o_out_valid | i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= CUR_RESET;
        end else if (i_cfg_we) begin
            r_cur <= i_cfg_wdata;
        end
    end

    // stage 1: doubled offsets
    logic               r1_v;
    logic signed [33:0] r1_dx, r1_dz;
    logic        [31:0] r1_area;
    logic signed [33:0] w_dx, w_dz;

    assign w_dx = (34'(i_in_item.receiver_x) <<< 1) - 34'(i_in_item.cell_x_left)
                  - 34'(i_in_item.cell_x_right);
    assign w_dz = (34'(i_in_item.receiver_z) <<< 1) - 34'(i_in_item.cell_z_left)
                  - 34'(i_in_item.cell_z_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dx   <= w_dx;
            r1_dz   <= w_dz;
            r1_area <= i_in_item.cell_area;
        end
    end

    // stage 2: magnitudes, common shift, area and current mantissas
    logic        r2_v, r2_nxz, r2_coinc, r2_cneg;
    logic [30:0] r2_ax, r2_az;
    logic [1:0]  r2_s;
    t_mf         r2_a, r2_c;
    logic [33:0] w_ax, w_az, w_or;
    logic [1:0]  w_s;
    logic [31:0] w_cmag;
    logic [5:0]  w_lza, w_lzc;

    always_comb begin
        w_ax   = r1_dx[33] ? 34'(-r1_dx) : 34'(r1_dx);
        w_az   = r1_dz[33] ? 34'(-r1_dz) : 34'(r1_dz);
        w_or   = w_ax | w_az;
        if (w_or[33]) begin
            w_s = 2'd3;
        end else if (w_or[32]) begin
            w_s = 2'd2;
        end else if (w_or[31]) begin
            w_s = 2'd1;
        end else begin
            w_s = 2'd0;
        end
        w_cmag = r_cur[31] ? (~r_cur + 32'd1) : r_cur;
        w_lza  = lzc32(r1_area);
        w_lzc  = lzc32(w_cmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ax    <= 31'(w_ax >> w_s);
            r2_az    <= 31'(w_az >> w_s);
            r2_s     <= w_s;
            r2_nxz   <= r1_dx[33] ^ r1_dz[33];
            r2_coinc <= (r1_dx == '0) && (r1_dz == '0);
            r2_cneg  <= r_cur[31];
            r2_a.m   <= r1_area << w_lza;
            r2_a.e   <= t_exp'(-FRAC_BITS) - t_exp'(w_lza);
            r2_c.m   <= w_cmag << w_lzc;
            r2_c.e   <= t_exp'(-FRAC_BITS) - t_exp'(w_lzc);
        end
    end

    // stage 3: squares and cross product
    logic        r3_v, r3_nxz, r3_coinc, r3_cneg;
    logic [61:0] r3_sxx, r3_szz, r3_sxz;
    logic [63:0] r3_ac;
    t_exp        r3_ace, r3_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_sxx   <= 62'(r2_ax) * 62'(r2_ax);
            r3_szz   <= 62'(r2_az) * 62'(r2_az);
            r3_sxz   <= 62'(r2_ax) * 62'(r2_az);
            r3_ac    <= 64'(r2_a.m) * 64'(r2_c.m);
            r3_ace   <= r2_a.e + r2_c.e;
            r3_e0    <= t_exp'(r2_s) - t_exp'(FRAC_BITS + 1);
            r3_nxz   <= r2_nxz;
            r3_coinc <= r2_coinc;
            r3_cneg  <= r2_cneg;
        end
    end

    // stage 4: r^2 and numerators
    logic        r4_v, r4_nxx, r4_nzz, r4_nxz, r4_coinc, r4_cneg;
    logic [63:0] r4_r2n, r4_mxx, r4_mzz, r4_mxz;
    t_mf         r4_ac;
    t_exp        r4_e0;
    logic [63:0] w_pxx, w_qxx, w_pzz, w_qzz;

    assign w_pxx = 64'(r3_sxx) << 1;
    assign w_qxx = 64'(r3_szz);
    assign w_pzz = 64'(r3_szz) << 1;
    assign w_qzz = 64'(r3_sxx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_r2n   <= 64'(r3_sxx) + 64'(r3_szz);
            r4_nxx   <= w_pxx < w_qxx;
            r4_mxx   <= (w_pxx < w_qxx) ? w_qxx - w_pxx : w_pxx - w_qxx;
            r4_nzz   <= w_pzz < w_qzz;
            r4_mzz   <= (w_pzz < w_qzz) ? w_qzz - w_pzz : w_pzz - w_qzz;
            r4_mxz   <= (64'(r3_sxz) << 1) + 64'(r3_sxz);
            r4_ac    <= norm_prod(r3_ac, r3_ace);
            r4_e0    <= r3_e0;
            r4_nxz   <= r3_nxz;
            r4_coinc <= r3_coinc;
            r4_cneg  <= r3_cneg;
        end
    end

    // stage 5: leading-zero counts, area*current/(4*pi)
    logic        r5_v, r5_nxx, r5_nzz, r5_nxz, r5_coinc, r5_cneg;
    logic [63:0] r5_r2n, r5_mxx, r5_mzz, r5_mxz, r5_num;
    logic [6:0]  r5_lzr, r5_lzxx, r5_lzxz, r5_lzzz;
    t_exp        r5_nume, r5_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_r2n   <= r4_r2n;
            r5_mxx   <= r4_mxx;
            r5_mzz   <= r4_mzz;
            r5_mxz   <= r4_mxz;
            r5_lzr   <= lzc64(r4_r2n);
            r5_lzxx  <= lzc64(r4_mxx);
            r5_lzxz  <= lzc64(r4_mxz);
            r5_lzzz  <= lzc64(r4_mzz);
            r5_num   <= 64'(r4_ac.m) * 64'(INV4PI_MANT);
            r5_nume  <= r4_ac.e + INV4PI_EXP;
            r5_e0    <= r4_e0;
            r5_nxx   <= r4_nxx;
            r5_nzz   <= r4_nzz;
            r5_nxz   <= r4_nxz;
            r5_coinc <= r4_coinc;
            r5_cneg  <= r4_cneg;
        end
    end

    // stage 6: normalize, build context, sqrt operand
    logic        r6_v;
    logic [63:0] r6_t;
    t_ctx        r6_ctx;
    t_ctx        w_ctx6;

    always_comb begin
        w_ctx6          = '0;
        w_ctx6.coinc    = r5_coinc;
        w_ctx6.cneg     = r5_cneg;
        w_ctx6.nxx      = r5_nxx;
        w_ctx6.nxz      = r5_nxz;
        w_ctx6.nzz      = r5_nzz;
        w_ctx6.e0       = r5_e0;
        w_ctx6.khalf    = r5_lzr[6:1];
        w_ctx6.rn.m     = norm64(r5_r2n, r5_lzr);
        w_ctx6.rn.e     = t_exp'(32) - t_exp'(r5_lzr);
        w_ctx6.num      = norm_prod(r5_num, r5_nume);
        w_ctx6.nm[0].m  = norm64(r5_mxx, r5_lzxx);
        w_ctx6.nm[0].e  = t_exp'(32) - t_exp'(r5_lzxx);
        w_ctx6.nm[1].m  = norm64(r5_mxz, r5_lzxz);
        w_ctx6.nm[1].e  = t_exp'(32) - t_exp'(r5_lzxz);
        w_ctx6.nm[2].m  = norm64(r5_mzz, r5_lzzz);
        w_ctx6.nm[2].e  = t_exp'(32) - t_exp'(r5_lzzz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_t   <= r5_r2n << {r5_lzr[6:1], 1'b0};
            r6_ctx <= w_ctx6;
        end
    end

    // square root, one result bit per stage
    logic        r_sq_v   [SQ_STEPS];
    logic [63:0] r_sq_n   [SQ_STEPS];
    logic [63:0] r_sq_res [SQ_STEPS];
    t_ctx        r_sq_ctx [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [63:0] w_n, w_res, w_one, w_sum;
        logic        w_v;
        t_ctx        w_c;
        if (i == 0) begin : g_first
            assign w_n   = r6_t;
            assign w_res = '0;
            assign w_v   = r6_v;
            assign w_c   = r6_ctx;
        end else begin : g_next
            assign w_n   = r_sq_n[i-1];
            assign w_res = r_sq_res[i-1];
            assign w_v   = r_sq_v[i-1];
            assign w_c   = r_sq_ctx[i-1];
        end
        assign w_one = 64'(1) << (62 - 2 * i);
        assign w_sum = w_res + w_one;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else if (w_adv) begin
                r_sq_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_n >= w_sum) begin
                    r_sq_n[i]   <= w_n - w_sum;
                    r_sq_res[i] <= (w_res >> 1) + w_one;
                end else begin
                    r_sq_n[i]   <= w_n;
                    r_sq_res[i] <= w_res >> 1;
                end
                r_sq_ctx[i] <= w_c;
            end
        end
    end

    // r^3 = r^2 * r
    logic        r_p1_v, r_p2_v;
    logic [63:0] r_p1_prod;
    t_exp        r_p1_e;
    t_ctx        r_p1_ctx, r_p2_ctx;
    logic [31:0] r_p2_d;
    t_ctx        w_sqc;
    t_mf         w_r3;
    t_ctx        w_p2c;

    assign w_sqc = r_sq_ctx[SQ_STEPS-1];
    assign w_r3  = norm_prod(r_p1_prod, r_p1_e);

    always_comb begin
        w_p2c     = r_p1_ctx;
        w_p2c.c.m = '0;
        w_p2c.c.e = r_p1_ctx.num.e - t_exp'(32) - w_r3.e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else if (w_adv) begin
            r_p1_v <= r_sq_v[SQ_STEPS-1];
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_prod <= 64'(w_sqc.rn.m) * 64'(r_sq_res[SQ_STEPS-1][31:0]);
            r_p1_e    <= w_sqc.e0 + w_sqc.e0 + w_sqc.e0 + w_sqc.rn.e - t_exp'(w_sqc.khalf);
            r_p1_ctx  <= w_sqc;
            r_p2_d    <= w_r3.m;
            r_p2_ctx  <= w_p2c;
        end
    end

    // coefficient divider
    logic        r_dc_v   [DIV_STEPS];
    logic [32:0] r_dc_rem [DIV_STEPS];
    logic [32:0] r_dc_q   [DIV_STEPS];
    logic [31:0] r_dc_d   [DIV_STEPS];
    t_ctx        r_dc_ctx [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dc
        logic [32:0] w_rem, w_q;
        logic [31:0] w_d;
        logic [33:0] w_st;
        logic        w_v;
        t_ctx        w_c;
        if (j == 0) begin : g_first
            assign w_rem = {1'b0, r_p2_ctx.num.m};
            assign w_q   = '0;
            assign w_d   = r_p2_d;
            assign w_v   = r_p2_v;
            assign w_c   = r_p2_ctx;
        end else begin : g_next
            assign w_rem = {r_dc_rem[j-1][31:0], 1'b0};
            assign w_q   = r_dc_q[j-1];
            assign w_d   = r_dc_d[j-1];
            assign w_v   = r_dc_v[j-1];
            assign w_c   = r_dc_ctx[j-1];
        end
        assign w_st = div_step(w_rem, w_d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dc_v[j] <= 1'b0;
            end else if (w_adv) begin
                r_dc_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dc_rem[j] <= w_st[32:0];
                r_dc_q[j]   <= {w_q[31:0], w_st[33]};
                r_dc_d[j]   <= w_d;
                r_dc_ctx[j] <= w_c;
            end
        end
    end

    // coefficient times numerators
    logic             r_c0_v, r_c1_v, r_c2_v;
    t_ctx             r_c0_ctx, r_c1_ctx, r_c2_ctx;
    logic [2:0][63:0] r_c1_prod;
    t_exp             r_c1_e [3];
    logic [31:0]      r_c2_m [3];
    t_exp             r_c2_e [3];
    t_ctx             w_dcc;
    t_ctx             w_c0c;
    t_mf              w_tp [3];

    assign w_dcc = r_dc_ctx[DIV_STEPS-1];

    always_comb begin
        w_c0c   = w_dcc;
        w_c0c.c = norm_quot(r_dc_q[DIV_STEPS-1], w_dcc.c.e);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_tp[k] = norm_prod(r_c1_prod[k], r_c1_e[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (w_adv) begin
            r_c0_v <= r_dc_v[DIV_STEPS-1];
            r_c1_v <= r_c0_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c0_ctx   <= w_c0c;
            r_c1_ctx   <= r_c0_ctx;
            r_c2_ctx   <= r_c1_ctx;
            for (int k = 0; k < 3; k++) begin
                r_c1_prod[k] <= 64'(r_c0_ctx.c.m) * 64'(r_c0_ctx.nm[k].m);
                r_c1_e[k]    <= r_c0_ctx.c.e + r_c0_ctx.nm[k].e;
                r_c2_m[k]    <= w_tp[k].m;
                r_c2_e[k]    <= w_tp[k].e - t_exp'(32) - r_c1_ctx.rn.e;
            end
        end
    end

    // three-lane term divider, shared divisor
    logic             r_dt_v   [DIV_STEPS];
    logic [2:0][32:0] r_dt_rem [DIV_STEPS];
    logic [2:0][32:0] r_dt_q   [DIV_STEPS];
    logic [2:0][EW-1:0] r_dt_e [DIV_STEPS];
    t_ctx             r_dt_ctx [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dt
        logic [2:0][32:0]   w_rem, w_q;
        logic [2:0][33:0]   w_st;
        logic [2:0][EW-1:0] w_e;
        logic               w_v;
        t_ctx               w_c;
        if (j == 0) begin : g_first
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign w_rem[k] = {1'b0, r_c2_m[k]};
                assign w_e[k]   = r_c2_e[k];
            end
            assign w_q = '0;
            assign w_v = r_c2_v;
            assign w_c = r_c2_ctx;
        end else begin : g_next
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign w_rem[k] = {r_dt_rem[j-1][k][31:0], 1'b0};
            end
            assign w_e = r_dt_e[j-1];
            assign w_q = r_dt_q[j-1];
            assign w_v = r_dt_v[j-1];
            assign w_c = r_dt_ctx[j-1];
        end
        for (genvar k = 0; k < 3; k++) begin : g_step
            assign w_st[k] = div_step(w_rem[k], w_c.rn.m);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dt_v[j] <= 1'b0;
            end else if (w_adv) begin
                r_dt_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int k = 0; k < 3; k++) begin
                    r_dt_rem[j][k] <= w_st[k][32:0];
                    r_dt_q[j][k]   <= {w_q[k][31:0], w_st[k][33]};
                end
                r_dt_e[j]   <= w_e;
                r_dt_ctx[j] <= w_c;
            end
        end
    end

    // fixed-point conversion
    logic        r_t0_v, r_t1_v;
    logic [31:0] r_t0_mag  [3];
    logic        r_t0_over [3];
    t_ctx        r_t0_ctx;
    t_out        r_t1_item;
    t_mf         w_tq   [3];
    t_exp        w_sh   [3];
    t_exp        w_rs   [3];
    logic [31:0] w_mag  [3];
    logic        w_neg  [3];
    logic [31:0] w_lim  [3];
    logic        w_sat  [3];
    logic [31:0] w_fix  [3];
    t_out        w_item;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_tq[k] = norm_quot(r_dt_q[DIV_STEPS-1][k], $signed(r_dt_e[DIV_STEPS-1][k]));
            w_sh[k] = w_tq[k].e + t_exp'(FRAC_BITS);
            w_rs[k] = -w_sh[k];
            if (w_sh[k] > t_exp'(0) || w_sh[k] < t_exp'(-31)) begin
                w_mag[k] = '0;
            end else begin
                w_mag[k] = w_tq[k].m >> w_rs[k][4:0];
            end
        end
        w_neg[0] = r_t0_ctx.cneg ^ r_t0_ctx.nxx;
        w_neg[1] = r_t0_ctx.cneg ^ r_t0_ctx.nxz;
        w_neg[2] = r_t0_ctx.cneg ^ r_t0_ctx.nzz;
        for (int k = 0; k < 3; k++) begin
            w_lim[k] = w_neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_sat[k] = r_t0_over[k] || (r_t0_mag[k] > w_lim[k]);
            w_fix[k] = w_sat[k] ? w_lim[k] : r_t0_mag[k];
            if (w_neg[k]) w_fix[k] = ~w_fix[k] + 32'd1;
        end
        w_item.term_xx    = w_fix[0];
        w_item.term_xz    = w_fix[1];
        w_item.term_zz    = w_fix[2];
        w_item.saturated  = w_sat[0] | w_sat[1] | w_sat[2];
        w_item.coincident = 1'b0;
        if (r_t0_ctx.coinc) begin
            w_item            = '0;
            w_item.coincident = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v <= 1'b0;
            r_t1_v <= 1'b0;
        end else if (w_adv) begin
            r_t0_v <= r_dt_v[DIV_STEPS-1];
            r_t1_v <= r_t0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_t0_mag[k]  <= w_mag[k];
                r_t0_over[k] <= (w_tq[k].m != '0) && (w_sh[k] > t_exp'(0));
            end
            r_t0_ctx  <= r_dt_ctx[DIV_STEPS-1];
            r_t1_item <= w_item;
        end
    end

    assign o_out_valid = r_t1_v;
    assign o_out_item  = r_t1_item;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output register empty");

    a_stall_freezes_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_sq_v[SQ_STEPS-1])
            && $stable(r_sq_res[SQ_STEPS-1]))
        else $error("pipeline moved during output stall");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.coincident) |-> (o_out_item.term_xx == '0)
            && (o_out_item.term_xz == '0) && (o_out_item.term_zz == '0)
            && !o_out_item.saturated)
        else $error("coincident item with nonzero terms");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.saturated) |->
            (o_out_item.term_xx == 32'sh7FFF_FFFF || o_out_item.term_xx == 32'sh8000_0000
            || o_out_item.term_xz == 32'sh7FFF_FFFF || o_out_item.term_xz == 32'sh8000_0000
            || o_out_item.term_zz == 32'sh7FFF_FFFF || o_out_item.term_zz == 32'sh8000_0000))
        else $error("saturation flag without a clipped term");
`endif

endmodule
